// ===== rtl/core/alle_pkg.sv =====
// Shared types and codes for the array-backed linked list engine.
// Holds the transaction structs, action and status codes and store controls.
// No dependencies.
package alle_pkg;

   // Default number of entries in the list store.
   localparam int LIST_ENTRIES_DEFAULT = 16;

   // Action codes carried in a request transaction.
   localparam logic [3:0] ACT_CREATE  = 4'd0;
   localparam logic [3:0] ACT_HEAD    = 4'd1;
   localparam logic [3:0] ACT_TAIL    = 4'd2;
   localparam logic [3:0] ACT_SORTED  = 4'd3;
   localparam logic [3:0] ACT_DELETE  = 4'd4;
   localparam logic [3:0] ACT_EXISTS  = 4'd5;
   localparam logic [3:0] ACT_MODIFY  = 4'd6;
   localparam logic [3:0] ACT_COUNT   = 4'd7;
   localparam logic [3:0] ACT_REORDER = 4'd8;
   localparam logic [3:0] ACT_FIND    = 4'd9;

   // Status codes returned in a response transaction.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_MISSING = 2'd2;

   // Request transaction payload.
   typedef struct packed {
      logic [3:0]         action;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [1:0] status;
      logic [4:0] element_count;
      logic [3:0] entry_index;
   } rsp_type;

   // Strobes from the sequencer to the entry store.
   typedef struct packed {
      logic rd_en;
      logic val_we;
      logic lnk_we;
      logic relink;
   } store_ctl_type;

endpackage

// ===== rtl/core/array_linked_list_engine.sv =====
// Top level of the array-backed linked list engine.
// Depends on alle_pkg and alle_store.
//
// Usage:
//   A request transaction carries an action, a value and a new value. Each
//   request gives exactly one response transaction with a status, an element
//   count (count action only) and an entry index (find action only).
//   One request is worked on at a time; req_stall is high from acceptance
//   until its response has been taken.
// Timing:
//   The sequencer walks the list one link per cycle through the store's single
//   registered read port.
// Reset:
//   The list is empty, all entries sit on the free chain from entry 0. Value
//   contents are undefined until written; no clearing pass is needed.
// Stall:
//   The response is held in registers while rsp_stall is high; no new
//   request is taken until it has been delivered.
module array_linked_list_engine #(
   parameter int LIST_ENTRIES = alle_pkg::LIST_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  alle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output alle_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(LIST_ENTRIES);
   localparam int LINK_W = $clog2(LIST_ENTRIES+1);
   localparam int CNT_W  = $clog2(LIST_ENTRIES+1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(LIST_ENTRIES);

   // Sequencer states.
   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_CREATE     = 12'b0000_0000_0010,
      ST_INS_CHK    = 12'b0000_0000_0100,
      ST_WALK_START = 12'b0000_0000_1000,
      ST_WALK       = 12'b0000_0001_0000,
      ST_WALK_END   = 12'b0000_0010_0000,
      ST_UNLINK     = 12'b0000_0100_0000,
      ST_FREE_RD    = 12'b0000_1000_0000,
      ST_FREE_TAKE  = 12'b0001_0000_0000,
      ST_PATCH      = 12'b0010_0000_0000,
      ST_STAGE_END  = 12'b0100_0000_0000,
      ST_RESP       = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         action_ff, action_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] new_value_ff, new_value_in;
   logic               phase_ff, phase_in;
   logic [1:0]         status_ff, status_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  tail_ff, tail_in;
   logic [LINK_W-1:0]  free_ff, free_in;
   logic [LINK_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0]  prev_ff, prev_in;
   logic [LINK_W-1:0]  next_ff, next_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic [IDX_W-1:0]   patch_addr_ff, patch_addr_in;
   logic [LINK_W-1:0]  patch_data_ff, patch_data_in;

   alle_pkg::store_ctl_type store_ctl;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   val_waddr;
   logic signed [31:0] val_wdata;
   logic [IDX_W-1:0]   lnk_waddr;
   logic [LINK_W-1:0]  lnk_wdata;
   logic signed [31:0] val_rd;
   logic [LINK_W-1:0]  link_rd;

   logic               sort_mode;
   logic               count_mode;
   logic               walk_stop;
   logic [31:0]        count_wide;
   logic [31:0]        index_wide;

   function automatic logic is_entry(input logic [LINK_W-1:0] p);
      return p < NIL;
   endfunction

   alle_store #(
      .LIST_ENTRIES(LIST_ENTRIES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (store_ctl),
      .rd_addr   (rd_addr),
      .val_waddr (val_waddr),
      .val_wdata (val_wdata),
      .lnk_waddr (lnk_waddr),
      .lnk_wdata (lnk_wdata),
      .val_rd    (val_rd),
      .link_rd   (link_rd)
   );

   // Walk mode: sorted walks stop at the first strictly greater value,
   // counting walks run to the end, all others stop at the first match.
   assign sort_mode  = (action_ff == alle_pkg::ACT_SORTED) ||
                       ((action_ff == alle_pkg::ACT_REORDER) && phase_ff);
   assign count_mode = (action_ff == alle_pkg::ACT_COUNT);
   assign walk_stop  = sort_mode  ? (target_ff < val_rd) :
                       count_mode ? 1'b0 : (val_rd == target_ff);

   // Sequencer next-state and store control.
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      target_in     = target_ff;
      new_value_in  = new_value_ff;
      phase_in      = phase_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      count_in      = count_ff;
      index_in      = index_ff;
      patch_addr_in = patch_addr_ff;
      patch_data_in = patch_data_ff;
      store_ctl     = '0;
      rd_addr       = cur_ff[IDX_W-1:0];
      val_waddr     = cur_ff[IDX_W-1:0];
      val_wdata     = target_ff;
      lnk_waddr     = cur_ff[IDX_W-1:0];
      lnk_wdata     = NIL;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in    = req_data.action;
               target_in    = req_data.value;
               new_value_in = req_data.new_value;
               phase_in     = 1'b0;
               status_in    = alle_pkg::STAT_OK;
               index_in     = '0;
               count_in     = '0;
               case (req_data.action)
                  alle_pkg::ACT_CREATE: begin
                     state_in = ST_CREATE;
                  end
                  alle_pkg::ACT_HEAD, alle_pkg::ACT_TAIL, alle_pkg::ACT_SORTED: begin
                     state_in = ST_INS_CHK;
                  end
                  alle_pkg::ACT_DELETE, alle_pkg::ACT_EXISTS, alle_pkg::ACT_MODIFY,
                  alle_pkg::ACT_COUNT, alle_pkg::ACT_REORDER, alle_pkg::ACT_FIND: begin
                     state_in = ST_WALK_START;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Relink the whole store: entry 0 holds the value, the rest are free.
         ST_CREATE: begin
            store_ctl.val_we = 1'b1;
            store_ctl.lnk_we = 1'b1;
            store_ctl.relink = 1'b1;
            val_waddr        = '0;
            lnk_waddr        = '0;
            lnk_wdata        = NIL;
            head_in          = '0;
            tail_in          = '0;
            free_in          = LINK_W'(1);
            state_in         = ST_RESP;
         end

         // Every insert needs a free entry.
         ST_INS_CHK: begin
            if (!is_entry(free_ff)) begin
               status_in = alle_pkg::STAT_FULL;
               state_in  = ST_RESP;
            end else if ((action_ff == alle_pkg::ACT_HEAD) ||
                         (action_ff == alle_pkg::ACT_TAIL)) begin
               state_in = ST_FREE_RD;
            end else begin
               state_in = ST_WALK_START;
            end
         end

         // Start a walk at the head.
         ST_WALK_START: begin
            cur_in   = head_ff;
            prev_in  = NIL;
            count_in = '0;
            rd_addr  = head_ff[IDX_W-1:0];
            if (is_entry(head_ff)) begin
               store_ctl.rd_en = 1'b1;
               state_in        = ST_WALK;
            end else begin
               state_in = ST_WALK_END;
            end
         end

         // One element per cycle: the current entry's data is in the store's
         // read registers, and the next entry is read straight away.
         ST_WALK: begin
            if (walk_stop) begin
               next_in  = link_rd;
               state_in = ST_WALK_END;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rd;
               count_in = count_ff + CNT_W'(1);
               rd_addr  = link_rd[IDX_W-1:0];
               if (is_entry(link_rd)) begin
                  store_ctl.rd_en = 1'b1;
               end else begin
                  state_in = ST_WALK_END;
               end
            end
         end

         // Act on the outcome of the walk.
         ST_WALK_END: begin
            if (sort_mode) begin
               state_in = ST_FREE_RD;
            end else begin
               case (action_ff)
                  alle_pkg::ACT_DELETE, alle_pkg::ACT_REORDER: begin
                     if (is_entry(cur_ff)) begin
                        state_in = ST_UNLINK;
                     end else begin
                        if (action_ff == alle_pkg::ACT_DELETE) begin
                           status_in = alle_pkg::STAT_MISSING;
                        end
                        state_in = ST_STAGE_END;
                     end
                  end
                  alle_pkg::ACT_MODIFY: begin
                     if (is_entry(cur_ff)) begin
                        store_ctl.val_we = 1'b1;
                        val_wdata        = new_value_ff;
                     end else begin
                        status_in = alle_pkg::STAT_MISSING;
                     end
                     state_in = ST_RESP;
                  end
                  alle_pkg::ACT_FIND: begin
                     if (is_entry(cur_ff)) begin
                        index_in = cur_ff[IDX_W-1:0];
                     end else begin
                        status_in = alle_pkg::STAT_MISSING;
                     end
                     state_in = ST_RESP;
                  end
                  alle_pkg::ACT_EXISTS: begin
                     if (!is_entry(cur_ff)) begin
                        status_in = alle_pkg::STAT_MISSING;
                     end
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Unlink the matched entry and push it onto the free chain.
         ST_UNLINK: begin
            store_ctl.lnk_we = 1'b1;
            lnk_waddr        = cur_ff[IDX_W-1:0];
            lnk_wdata        = free_ff;
            free_in          = cur_ff;
            if (tail_ff == cur_ff) begin
               tail_in = prev_ff;
            end
            if (is_entry(prev_ff)) begin
               patch_addr_in = prev_ff[IDX_W-1:0];
               patch_data_in = next_ff;
               state_in      = ST_PATCH;
            end else begin
               head_in  = next_ff;
               state_in = ST_STAGE_END;
            end
         end

         // Read the free head's link to find the new free head.
         ST_FREE_RD: begin
            store_ctl.rd_en = 1'b1;
            rd_addr         = free_ff[IDX_W-1:0];
            state_in        = ST_FREE_TAKE;
         end

         // Fill the taken entry and hook it into the list.
         ST_FREE_TAKE: begin
            store_ctl.val_we = 1'b1;
            store_ctl.lnk_we = 1'b1;
            val_waddr        = free_ff[IDX_W-1:0];
            lnk_waddr        = free_ff[IDX_W-1:0];
            free_in          = link_rd;
            state_in         = ST_STAGE_END;
            if (action_ff == alle_pkg::ACT_HEAD) begin
               lnk_wdata = head_ff;
               head_in   = free_ff;
               if (!is_entry(tail_ff)) begin
                  tail_in = free_ff;
               end
            end else if (action_ff == alle_pkg::ACT_TAIL) begin
               lnk_wdata = NIL;
               tail_in   = free_ff;
               if (is_entry(tail_ff)) begin
                  patch_addr_in = tail_ff[IDX_W-1:0];
                  patch_data_in = free_ff;
                  state_in      = ST_PATCH;
               end else begin
                  head_in = free_ff;
               end
            end else begin
               lnk_wdata = cur_ff;
               if (!is_entry(cur_ff)) begin
                  tail_in = free_ff;
               end
               if (is_entry(prev_ff)) begin
                  patch_addr_in = prev_ff[IDX_W-1:0];
                  patch_data_in = free_ff;
                  state_in      = ST_PATCH;
               end else begin
                  head_in = free_ff;
               end
            end
         end

         // Second link write of an insert or delete.
         ST_PATCH: begin
            store_ctl.lnk_we = 1'b1;
            lnk_waddr        = patch_addr_ff;
            lnk_wdata        = patch_data_ff;
            state_in         = ST_STAGE_END;
         end

         // Modify-reorder moves on from its delete to its sorted insert.
         ST_STAGE_END: begin
            if ((action_ff == alle_pkg::ACT_REORDER) && !phase_ff) begin
               phase_in  = 1'b1;
               target_in = new_value_ff;
               state_in  = ST_INS_CHK;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         free_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      target_ff     <= target_in;
      new_value_ff  <= new_value_in;
      phase_ff      <= phase_in;
      status_ff     <= status_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      count_ff      <= count_in;
      index_ff      <= index_in;
      patch_addr_ff <= patch_addr_in;
      patch_data_ff <= patch_data_in;
   end

   // Response transaction, taken straight from registers.
   assign count_wide = 32'(count_ff);
   assign index_wide = 32'(index_ff);
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_data.status        = status_ff;
   assign rsp_data.element_count = (action_ff == alle_pkg::ACT_COUNT) ? count_wide[4:0] : 5'd0;
   assign rsp_data.entry_index   = index_wide[3:0];

endmodule

// ===== rtl/core/alle_store.sv =====
// Entry store of the linked list engine: value memory and link memory.
// Link entries never written since reset or relink read as the free-chain default.
// Depends on alle_pkg.
module alle_store #(
   parameter int LIST_ENTRIES = alle_pkg::LIST_ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  alle_pkg::store_ctl_type              ctl,
   input  logic [$clog2(LIST_ENTRIES)-1:0]      rd_addr,
   input  logic [$clog2(LIST_ENTRIES)-1:0]      val_waddr,
   input  logic signed [31:0]                   val_wdata,
   input  logic [$clog2(LIST_ENTRIES)-1:0]      lnk_waddr,
   input  logic [$clog2(LIST_ENTRIES+1)-1:0]    lnk_wdata,
   output logic signed [31:0]                   val_rd,
   output logic [$clog2(LIST_ENTRIES+1)-1:0]    link_rd
);

   localparam int IDX_W  = $clog2(LIST_ENTRIES);
   localparam int LINK_W = $clog2(LIST_ENTRIES+1);

   logic signed [31:0]  value_mem [LIST_ENTRIES];
   logic [LINK_W-1:0]   link_mem  [LIST_ENTRIES];
   logic [LIST_ENTRIES-1:0] valid_ff;
   logic signed [31:0]  val_q_ff;
   logic [LINK_W-1:0]   lnk_q_ff;
   logic                lv_q_ff;
   logic [IDX_W-1:0]    addr_q_ff;

   // Value memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.val_we) begin
         value_mem[val_waddr] <= val_wdata;
      end
      if (ctl.rd_en) begin
         val_q_ff <= value_mem[rd_addr];
      end
   end

   // Link memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.lnk_we) begin
         link_mem[lnk_waddr] <= lnk_wdata;
      end
      if (ctl.rd_en) begin
         lnk_q_ff  <= link_mem[rd_addr];
         addr_q_ff <= rd_addr;
      end
   end

   // Written flags for the link memory. A relink clears them all at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         lv_q_ff  <= 1'b0;
      end else begin
         if (ctl.rd_en) begin
            lv_q_ff <= valid_ff[rd_addr];
         end
         if (ctl.relink) begin
            valid_ff <= '0;
         end
         if (ctl.lnk_we) begin
            valid_ff[lnk_waddr] <= 1'b1;
         end
      end
   end

   // An unwritten entry links to the next index; the last one links to null.
   assign val_rd  = val_q_ff;
   assign link_rd = lv_q_ff ? lnk_q_ff : LINK_W'(addr_q_ff) + LINK_W'(1);

endmodule

// ===== sim/list_engine_checker.sv =====
// Response checker for the array-backed linked list engine.
// Keeps its own copy of the list store, predicts every response and compares it.
// Depends on alle_pkg.
module list_engine_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  alle_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  alle_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = alle_pkg::LIST_ENTRIES_DEFAULT;
   localparam int PTR_W = $clog2(ENTRIES + 1);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

   // Shadow copy of the engine's store and pointers.
   logic signed [31:0] stored_val [ENTRIES];
   logic [PTR_W-1:0]   next_link [ENTRIES];
   logic [PTR_W-1:0]   head_ptr;
   logic [PTR_W-1:0]   tail_ptr;
   logic [PTR_W-1:0]   free_ptr;

   // Responses still owed by the engine, oldest first.
   alle_pkg::rsp_type expected_rsp_q [$];

   function automatic bit live(input logic [PTR_W-1:0] p);
      return p < ENTRIES;
   endfunction

   // Chains entries from 'first' up to the last one onto the free list.
   function automatic void relink_free(input int first);
      int i;
      for (i = first; i < ENTRIES; i++)
         next_link[i] = (i + 1 < ENTRIES) ? PTR_W'(i + 1) : NIL;
      free_ptr = (first < ENTRIES) ? PTR_W'(first) : NIL;
   endfunction

   function automatic void reset_model();
      int i;
      for (i = 0; i < ENTRIES; i++)
         stored_val[i] = '0;
      relink_free(0);
      head_ptr = NIL;
      tail_ptr = NIL;
   endfunction

   // First entry holding v from the head, with the entry before it.
   function automatic logic [PTR_W-1:0] locate(input logic signed [31:0] v,
                                                output logic [PTR_W-1:0] prior);
      logic [PTR_W-1:0] cur;
      int steps;
      cur = head_ptr;
      prior = NIL;
      for (steps = 0; steps < ENTRIES && live(cur); steps++) begin
         if (stored_val[cur] == v)
            return cur;
         prior = cur;
         cur = next_link[cur];
      end
      prior = NIL;
      return NIL;
   endfunction

   function automatic logic [PTR_W-1:0] take_entry(input logic signed [31:0] v);
      logic [PTR_W-1:0] slot;
      slot = free_ptr;
      free_ptr = next_link[slot];
      stored_val[slot] = v;
      return slot;
   endfunction

   function automatic logic [1:0] add_at_head(input logic signed [31:0] v);
      logic [PTR_W-1:0] slot;
      if (!live(free_ptr))
         return alle_pkg::STAT_FULL;
      slot = take_entry(v);
      next_link[slot] = head_ptr;
      head_ptr = slot;
      if (!live(tail_ptr))
         tail_ptr = slot;
      return alle_pkg::STAT_OK;
   endfunction

   function automatic logic [1:0] add_at_tail(input logic signed [31:0] v);
      logic [PTR_W-1:0] slot;
      if (!live(free_ptr))
         return alle_pkg::STAT_FULL;
      slot = take_entry(v);
      next_link[slot] = NIL;
      if (live(tail_ptr))
         next_link[tail_ptr] = slot;
      else
         head_ptr = slot;
      tail_ptr = slot;
      return alle_pkg::STAT_OK;
   endfunction

   // Places v before the first strictly greater value, or at the tail.
   function automatic logic [1:0] add_sorted(input logic signed [31:0] v);
      logic [PTR_W-1:0] cur;
      logic [PTR_W-1:0] prior;
      logic [PTR_W-1:0] slot;
      int steps;
      cur = head_ptr;
      prior = NIL;
      if (!live(free_ptr))
         return alle_pkg::STAT_FULL;
      for (steps = 0; steps < ENTRIES && live(cur); steps++) begin
         if (v < stored_val[cur])
            break;
         prior = cur;
         cur = next_link[cur];
      end
      if (!live(cur))
         cur = NIL;
      slot = take_entry(v);
      next_link[slot] = cur;
      if (live(prior))
         next_link[prior] = slot;
      else
         head_ptr = slot;
      if (!live(cur))
         tail_ptr = slot;
      return alle_pkg::STAT_OK;
   endfunction

   // Unlinks the first match of v and returns its entry to the free list.
   function automatic logic [1:0] remove_value(input logic signed [31:0] v);
      logic [PTR_W-1:0] hit;
      logic [PTR_W-1:0] prior;
      hit = locate(v, prior);
      if (!live(hit))
         return alle_pkg::STAT_MISSING;
      if (live(prior))
         next_link[prior] = next_link[hit];
      else
         head_ptr = next_link[hit];
      if (tail_ptr == hit)
         tail_ptr = prior;
      next_link[hit] = free_ptr;
      free_ptr = hit;
      return alle_pkg::STAT_OK;
   endfunction

   function automatic int list_length();
      logic [PTR_W-1:0] cur;
      int n;
      cur = head_ptr;
      n = 0;
      while (n < ENTRIES && live(cur)) begin
         n++;
         cur = next_link[cur];
      end
      return n;
   endfunction

   // Applies one request to the shadow store and returns the response it owes.
   function automatic alle_pkg::rsp_type predict_response(input alle_pkg::req_type item);
      alle_pkg::rsp_type outcome;
      logic [PTR_W-1:0] hit;
      logic [PTR_W-1:0] prior;
      outcome = '0;
      outcome.status = alle_pkg::STAT_OK;
      case (item.action)
         alle_pkg::ACT_CREATE: begin
            stored_val[0] = item.value;
            next_link[0] = NIL;
            head_ptr = '0;
            tail_ptr = '0;
            relink_free(1);
         end
         alle_pkg::ACT_HEAD:   outcome.status = add_at_head(item.value);
         alle_pkg::ACT_TAIL:   outcome.status = add_at_tail(item.value);
         alle_pkg::ACT_SORTED: outcome.status = add_sorted(item.value);
         alle_pkg::ACT_DELETE: outcome.status = remove_value(item.value);
         alle_pkg::ACT_EXISTS: begin
            hit = locate(item.value, prior);
            outcome.status = live(hit) ? alle_pkg::STAT_OK : alle_pkg::STAT_MISSING;
         end
         alle_pkg::ACT_MODIFY: begin
            hit = locate(item.value, prior);
            if (live(hit))
               stored_val[hit] = item.new_value;
            else
               outcome.status = alle_pkg::STAT_MISSING;
         end
         alle_pkg::ACT_COUNT:  outcome.element_count = 5'(list_length());
         alle_pkg::ACT_REORDER: begin
            // The insert goes ahead whether or not the old value was present.
            void'(remove_value(item.value));
            outcome.status = add_sorted(item.new_value);
         end
         alle_pkg::ACT_FIND: begin
            hit = locate(item.value, prior);
            if (live(hit))
               outcome.entry_index = 4'(hit);
            else
               outcome.status = alle_pkg::STAT_MISSING;
         end
         default: ;
      endcase
      return outcome;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   // Responses are matched before requests are queued, since a response taken
   // at an edge always belongs to an earlier request.
   always @(posedge clock) begin
      alle_pkg::rsp_type want;
      if (reset) begin
         reset_model();
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: expected no transaction, got status %0d count %0d index %0d",
                        $time, rsp_data.status, rsp_data.element_count,
                        rsp_data.entry_index);
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("status", want.status, rsp_data.status);
               compare_field("element_count", want.element_count, rsp_data.element_count);
               compare_field("entry_index", want.entry_index, rsp_data.entry_index);
            end
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(predict_response(req_data));
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

// ===== sim/tb_array_linked_list_engine.sv =====
// Testbench top for the array-backed linked list engine: clock, reset, stimulus
// and verdict. Depends on alle_pkg, array_linked_list_engine and list_engine_checker.
module tb_array_linked_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 520;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 64;
   localparam int POOL_SIZE = 6;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   alle_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   alle_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending_count;
   int                cycle_count = 0;
   bit                req_gaps = 1'b1;
   bit                rsp_gaps = 1'b1;

   // Values that recent transactions used, so that searches often hit.
   logic signed [31:0] value_pool [POOL_SIZE];

   always #2 clock = ~clock;

   array_linked_list_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   list_engine_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // The response side stalls at random while gaps are enabled.
   always @(negedge clock) begin
      rsp_stall <= rsp_gaps && ($urandom_range(0, 99) < 25);
   end

   // Watchdog: a hung engine ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic alle_pkg::req_type make_item(input logic [3:0] action,
                                                   input logic signed [31:0] value,
                                                   input logic signed [31:0] new_value);
      alle_pkg::req_type item;
      item.action = action;
      item.value = value;
      item.new_value = new_value;
      return item;
   endfunction

   // Extremes and small values are favoured so that ordering and duplicates matter.
   function automatic logic signed [31:0] fresh_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sd0;
         3: return -32'sd1;
         4, 5: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      int slot;
      slot = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 99) < 5)
         value_pool[slot] = fresh_value();
      if ($urandom_range(0, 99) < 80)
         return value_pool[slot];
      return fresh_value();
   endfunction

   // While growing, inserts dominate so the store fills; otherwise deletes win.
   function automatic logic [3:0] pick_action(input bit grow_list);
      int roll;
      int insert_top;
      roll = $urandom_range(0, 99);
      insert_top = grow_list ? 55 : 25;
      if (roll < 2)
         return alle_pkg::ACT_CREATE;
      if (roll < 4)
         return 4'($urandom_range(10, 15));
      if (roll < insert_top) begin
         case (roll % 3)
            0: return alle_pkg::ACT_HEAD;
            1: return alle_pkg::ACT_TAIL;
            default: return alle_pkg::ACT_SORTED;
         endcase
      end
      if (roll < insert_top + (grow_list ? 10 : 25))
         return alle_pkg::ACT_DELETE;
      case (roll % 5)
         0: return alle_pkg::ACT_EXISTS;
         1: return alle_pkg::ACT_MODIFY;
         2: return alle_pkg::ACT_COUNT;
         3: return alle_pkg::ACT_REORDER;
         default: return alle_pkg::ACT_FIND;
      endcase
   endfunction

   // Presents one transaction and returns at the falling edge after it is taken.
   // Entered at a falling edge at which valid has not yet been assigned.
   task automatic send_item(input alle_pkg::req_type item);
      while (req_gaps && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // Holds off new transactions until every response owed has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_count != 0);
   endtask

   initial begin
      bit grow_list;
      int i;
      grow_list = 1'b0;
      for (i = 0; i < POOL_SIZE; i++)
         value_pool[i] = fresh_value();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty list, inserts at both ends, sorted placement, searches.
      send_item(make_item(alle_pkg::ACT_COUNT, 32'sd0, 32'sd0));
      send_item(make_item(alle_pkg::ACT_FIND, 32'sd5, 32'sd0));
      send_item(make_item(alle_pkg::ACT_HEAD, 32'sh7FFF_FFFF, 32'sd0));
      send_item(make_item(alle_pkg::ACT_DELETE, 32'sh7FFF_FFFF, 32'sd0));
      send_item(make_item(alle_pkg::ACT_TAIL, 32'sh8000_0000, 32'sd0));
      send_item(make_item(alle_pkg::ACT_SORTED, 32'sd0, 32'sd0));
      send_item(make_item(alle_pkg::ACT_SORTED, -32'sd1, 32'sd0));
      send_item(make_item(alle_pkg::ACT_HEAD, 32'sd0, 32'sd0));
      send_item(make_item(alle_pkg::ACT_FIND, 32'sd0, 32'sd0));
      send_item(make_item(alle_pkg::ACT_EXISTS, 32'sd12345, 32'sd0));
      send_item(make_item(alle_pkg::ACT_MODIFY, -32'sd1, 32'sd7));
      send_item(make_item(alle_pkg::ACT_MODIFY, 32'sd999, 32'sd1));
      send_item(make_item(alle_pkg::ACT_REORDER, 32'sd7, 32'sh7FFF_FFFF));
      send_item(make_item(alle_pkg::ACT_REORDER, 32'sd42, -32'sd5));
      send_item(make_item(alle_pkg::ACT_DELETE, 32'sd123, 32'sd0));
      send_item(make_item(alle_pkg::ACT_DELETE, 32'sh7FFF_FFFF, 32'sd0));
      send_item(make_item(alle_pkg::ACT_COUNT, 32'sd0, 32'sd0));
      send_item(make_item(4'd10, 32'sd0, 32'sd0));
      send_item(make_item(4'hF, -32'sd1, -32'sd1));

      // Directed: rebuild, fill the store, then every insert path against a full store.
      send_item(make_item(alle_pkg::ACT_CREATE, 32'sh8000_0000, 32'sd0));
      for (i = 1; i < alle_pkg::LIST_ENTRIES_DEFAULT; i++)
         send_item(make_item(alle_pkg::ACT_TAIL, 32'(i * 3), 32'sd0));
      send_item(make_item(alle_pkg::ACT_HEAD, 32'sd1, 32'sd0));
      send_item(make_item(alle_pkg::ACT_SORTED, 32'sd1, 32'sd0));
      send_item(make_item(alle_pkg::ACT_TAIL, 32'sd1, 32'sd0));
      send_item(make_item(alle_pkg::ACT_REORDER, 32'sd2, 32'sd4));
      send_item(make_item(alle_pkg::ACT_REORDER, 32'sd3, 32'sd4));
      send_item(make_item(alle_pkg::ACT_COUNT, 32'sd0, 32'sd0));
      send_item(make_item(alle_pkg::ACT_FIND, 32'sd4, 32'sd0));
      drain_responses();

      // Random: alternating growth and shrinkage, with one stretch free of gaps.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0)
            grow_list = !grow_list;
         if (i == 200) begin
            req_gaps = 1'b0;
            rsp_gaps = 1'b0;
         end
         if (i == 300) begin
            req_gaps = 1'b1;
            rsp_gaps = 1'b1;
         end
         if (i % 150 == 75)
            drain_responses();
         send_item(make_item(pick_action(grow_list), pick_value(),
                             ($urandom_range(0, 1) == 1) ? pick_value() : fresh_value()));
      end

      // Wind down and give the verdict.
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
